>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> sv/ipdc_pkg.sv
// Package: widths, register indexes, reset values and shared structs for the PID core.
package ipdc_pkg;

  localparam int POS_W   = 24;
  localparam int ERR_W   = POS_W + 1;
  localparam int COEF_W  = 32;
  localparam int BAND_W  = 16;
  localparam int LIMIT_W = 15;
  localparam int DRIVE_W = 16;
  localparam int FRAC_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = COEF_W;
  localparam int PROD_W  = COEF_W + ERR_W;
  localparam int ACC_W   = PROD_W + 2;

  localparam logic [BAND_W-1:0]  DEAD_BAND_RST   = BAND_W'(358);
  localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST = LIMIT_W'(5888);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_NOW    = 3'd0,
    REG_COEF_LAST   = 3'd1,
    REG_COEF_BEFORE = 3'd2,
    REG_DEAD_BAND   = 3'd3,
    REG_DRIVE_LIMIT = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_now;
    logic signed [COEF_W-1:0] coef_last;
    logic signed [COEF_W-1:0] coef_before;
    logic [BAND_W-1:0]        dead_band;
    logic [LIMIT_W-1:0]       drive_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]   err_one;
    logic signed [ERR_W-1:0]   err_two;
    logic signed [DRIVE_W-1:0] drive_one;
  } hist_t;

endpackage

>>> sv/ipdc_cfg_regs.sv
// Configuration register file: coefficients, deadband and drive limit.
module ipdc_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ipdc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ipdc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output ipdc_pkg::cfg_t                     cfg_o
);
  import ipdc_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the write and update the addressed register
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_COEF_NOW:    cfg_d.coef_now    = $signed(cfg_wdata_i[COEF_W-1:0]);
        REG_COEF_LAST:   cfg_d.coef_last   = $signed(cfg_wdata_i[COEF_W-1:0]);
        REG_COEF_BEFORE: cfg_d.coef_before = $signed(cfg_wdata_i[COEF_W-1:0]);
        REG_DEAD_BAND:   cfg_d.dead_band   = cfg_wdata_i[BAND_W-1:0];
        REG_DRIVE_LIMIT: cfg_d.drive_limit = cfg_wdata_i[LIMIT_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_now    <= '0;
      cfg_q.coef_last   <= '0;
      cfg_q.coef_before <= '0;
      cfg_q.dead_band   <= DEAD_BAND_RST;
      cfg_q.drive_limit <= DRIVE_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/ipdc_law.sv
// Control law: deadband test, three-tap weighted sum, clamp and rounding.
module ipdc_law (
  input  ipdc_pkg::cfg_t                          cfg_i,
  input  ipdc_pkg::hist_t                         hist_i,
  input  logic signed [ipdc_pkg::ERR_W-1:0]       err_i,
  input  logic                                    clear_i,
  output logic signed [ipdc_pkg::DRIVE_W-1:0]     drive_o,
  output logic                                    in_position_o,
  output ipdc_pkg::hist_t                         hist_o
);
  import ipdc_pkg::*;

  logic signed [ERR_W:0]     err_x;
  logic signed [ERR_W:0]     band_x;
  logic                      in_band;
  hist_t                     hist_eff;
  logic signed [PROD_W-1:0]  prod_now, prod_last, prod_before;
  logic signed [2*FRAC_W-1:0] drive_scaled;
  logic signed [2*FRAC_W-1:0] lim_scaled;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   lim_x;
  logic signed [ACC_W-1:0]   rounded;
  logic signed [ACC_W-1:0]   shifted;
  logic signed [DRIVE_W-1:0] lim_drive;
  logic signed [DRIVE_W-1:0] drive_calc;

  // Drop the history on a clear request
  assign hist_eff = clear_i ? '0 : hist_i;

  // Open deadband test at the common Q.8 scale
  assign err_x   = (ERR_W+1)'(err_i);
  assign band_x  = $signed({(ERR_W+1-BAND_W)'(0), cfg_i.dead_band});
  assign in_band = (err_x < band_x) && (err_x > -band_x);

  // Weighted sum of the error taps plus the previous drive, all in Q.24
  assign prod_now     = PROD_W'(cfg_i.coef_now)    * PROD_W'(err_i);
  assign prod_last    = PROD_W'(cfg_i.coef_last)   * PROD_W'(hist_eff.err_one);
  assign prod_before  = PROD_W'(cfg_i.coef_before) * PROD_W'(hist_eff.err_two);
  assign drive_scaled = $signed({hist_eff.drive_one, FRAC_W'(0)});
  assign acc = ACC_W'(prod_now) + ACC_W'(prod_last) + ACC_W'(prod_before)
             + ACC_W'(drive_scaled);

  // Clamp against the scaled limit, otherwise round half up to Q8.8
  assign lim_scaled = $signed({1'b0, cfg_i.drive_limit, FRAC_W'(0)});
  assign lim_x      = ACC_W'(lim_scaled);
  assign lim_drive  = $signed({1'b0, cfg_i.drive_limit});
  assign rounded    = acc + ACC_W'(1 << (FRAC_W - 1));
  assign shifted    = rounded >>> FRAC_W;

  always_comb begin
    if (acc >= lim_x) begin
      drive_calc = lim_drive;
    end else if (acc <= -lim_x) begin
      drive_calc = -lim_drive;
    end else begin
      drive_calc = shifted[DRIVE_W-1:0];
    end
  end

  // Select the result and shift the history
  assign drive_o        = in_band ? '0 : drive_calc;
  assign in_position_o  = in_band;
  assign hist_o.err_two   = hist_eff.err_one;
  assign hist_o.err_one   = in_band ? '0 : err_i;
  assign hist_o.drive_one = drive_o;

endmodule

>>> sv/incremental_pid_deadband_clamp_core.sv
// An accepted request passes from the error register to the result register.
// Throughput: one request per cycle when the result is not stalled; the control
// law and history update sit in the single stage between error and result registers.
// A stalled result holds while one more request is buffered in the error register.
// Reset (async, active low) empties both stages, zeroes the history and
// restores register defaults.
module incremental_pid_deadband_clamp_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ipdc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ipdc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [ipdc_pkg::POS_W-1:0]    setpoint_i,
  input  logic signed [ipdc_pkg::POS_W-1:0]    measured_i,
  input  logic                                 clear_history_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [ipdc_pkg::DRIVE_W-1:0]  drive_o,
  output logic                                 in_position_o
);
  import ipdc_pkg::*;

  cfg_t                      cfg;
  hist_t                     hist_q, hist_d;
  logic                      s1_valid_q, s1_valid_d;
  logic signed [ERR_W-1:0]   err_q;
  logic                      clr_q;
  logic                      out_valid_q, out_valid_d;
  logic signed [DRIVE_W-1:0] drive_q;
  logic                      in_pos_q;
  logic                      accept;
  logic                      advance;
  logic signed [DRIVE_W-1:0] drive_calc;
  logic                      in_pos_calc;

  ipdc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ipdc_law u_law (
    .cfg_i         (cfg),
    .hist_i        (hist_q),
    .err_i         (err_q),
    .clear_i       (clr_q),
    .drive_o       (drive_calc),
    .in_position_o (in_pos_calc),
    .hist_o        (hist_d)
  );

  // Handshake: advance the stage when the result slot is free or being taken
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state and history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hist_q      <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        hist_q <= hist_d;
      end
    end
  end

  // Capture the error of each accepted request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      err_q <= ERR_W'(setpoint_i) - ERR_W'(measured_i);
      clr_q <= clear_history_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      drive_q  <= drive_calc;
      in_pos_q <= in_pos_calc;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_o       = drive_q;
  assign in_position_o = in_pos_q;

endmodule

>>> sv/ipdc_checker.sv
// Port-level checker for the PID core, bound to the top level.
`include "assert_macros.svh"

module ipdc_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_ready_o,
  input  logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  input  logic signed [ipdc_pkg::DRIVE_W-1:0]  drive_o,
  input  logic                                 in_position_o
);
  import ipdc_pkg::*;

  // Hold a stalled result unchanged
  `ASSERT_CLK(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(drive_o) && $stable(in_position_o), "stalled result changed")

  // Drive zero whenever the loop is in position
  `ASSERT_CLK(a_inpos_zero, out_valid_o && in_position_o |-> drive_o == '0, "in position with nonzero drive")

  // The clamp never reaches the most negative code
  `ASSERT_CLK(a_clamp_range, out_valid_o |-> drive_o != $signed({1'b1, (DRIVE_W-1)'(0)}), "drive beyond clamp")

  // Back-pressure only appears with a result pending
  `ASSERT_ALWAYS(a_ready_stall, !rst_ni || in_ready_o || out_valid_o, "input stalled with no result pending")

endmodule

bind incremental_pid_deadband_clamp_core ipdc_checker u_ipdc_checker (.*);
